[src/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// widths, constants, tables and shared types of the sine taylor series unit
// ----------------------------------------------------------------------------
package sts_pkg;

   // channel and register fields
   localparam int ANGLE_W = 32;
   localparam int SINE_W = 32;
   localparam int THR_W = 31;
   localparam logic [THR_W-1:0] THR_RESET = 31'd10737;
   localparam int DEFAULT_MAX_TERMS = 12;

   // range reduction, 48 fraction bits
   localparam int ANGLE_FRAC_SHIFT = 24;
   localparam int RED_W = 58;
   localparam logic [RED_W-1:0] PI_Q48 = RED_W'(64'h0003_243F_6A88_85A3);
   localparam logic [RED_W-1:0] TWO_PI_Q48 = RED_W'(64'h0006_487E_D511_0B46);
   localparam int FOLD_W = 3;
   localparam logic [FOLD_W-1:0] FOLD_TOP = 3'd5;
   localparam int XM_SHIFT = 18;
   localparam int XM_W = 32;

   // series arithmetic, 30 fraction bits
   localparam int FRAC_W = 30;
   localparam int X2_W = 34;
   localparam int SUM_W = 38;
   localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'd1073741824);
   localparam int KCNT_W = 5;
   localparam int TERM_SLOTS = 16;
   localparam int TERM_IDX_W = 4;

   // shared multiplier: a times b, b taken in chunks, most significant first
   localparam int MUL_A_W = 36;
   localparam int MUL_CHUNK_W = 18;
   localparam int MUL_B_W = 54;
   localparam int MUL_P_W = 90;
   localparam int MUL_CNT_W = 2;
   localparam logic [MUL_CNT_W-1:0] SQ_CHUNKS = 2'd2;
   localparam logic [MUL_CNT_W-1:0] PROD_CHUNKS = 2'd2;
   localparam logic [MUL_CNT_W-1:0] QUOT_CHUNKS = 2'd3;

   // division by (2k)(2k+1): reciprocal ceil(2^46 / d), exact for dividends below 2^36
   localparam int RECIP_SHIFT = 46;
   localparam int RECIP_W = 44;
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam int HALF_W = 10;

   localparam logic [RECIP_W-1:0] RECIP_TABLE [TERM_SLOTS] = '{
      RECIP_W'(64'd0),
      RECIP_W'((RECIP_ONE + 64'd5) / 64'd6),
      RECIP_W'((RECIP_ONE + 64'd19) / 64'd20),
      RECIP_W'((RECIP_ONE + 64'd41) / 64'd42),
      RECIP_W'((RECIP_ONE + 64'd71) / 64'd72),
      RECIP_W'((RECIP_ONE + 64'd109) / 64'd110),
      RECIP_W'((RECIP_ONE + 64'd155) / 64'd156),
      RECIP_W'((RECIP_ONE + 64'd209) / 64'd210),
      RECIP_W'((RECIP_ONE + 64'd271) / 64'd272),
      RECIP_W'((RECIP_ONE + 64'd341) / 64'd342),
      RECIP_W'((RECIP_ONE + 64'd419) / 64'd420),
      RECIP_W'((RECIP_ONE + 64'd505) / 64'd506),
      RECIP_W'((RECIP_ONE + 64'd599) / 64'd600),
      RECIP_W'((RECIP_ONE + 64'd701) / 64'd702),
      RECIP_W'((RECIP_ONE + 64'd811) / 64'd812),
      RECIP_W'((RECIP_ONE + 64'd929) / 64'd930)
   };

   // half divisor k(2k+1), added before the division for round to nearest
   localparam logic [HALF_W-1:0] HALF_TABLE [TERM_SLOTS] = '{
      10'd0, 10'd3, 10'd10, 10'd21, 10'd36, 10'd55, 10'd78, 10'd105,
      10'd136, 10'd171, 10'd210, 10'd253, 10'd300, 10'd351, 10'd406, 10'd465
   };

   typedef struct packed {
      logic start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic [MUL_CNT_W-1:0] chunks;
   } mul_cmd_type;

   typedef struct packed {
      logic done;
      logic [MUL_P_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic done;
      logic neg;
      logic [XM_W-1:0] xm;
   } red_rsp_type;

   typedef struct packed {
      logic done;
      logic [SINE_W-1:0] sine_value;
   } ser_rsp_type;

endpackage

[src/sts_req_if.sv]
// ----------------------------------------------------------------------------
// sts_req_if
// request channel: one angle per transaction
// ----------------------------------------------------------------------------
interface sts_req_if import sts_pkg::*; ();

   logic valid;
   logic ready;
   logic signed [ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);

endinterface

[src/sts_rsp_if.sv]
// ----------------------------------------------------------------------------
// sts_rsp_if
// response channel: one sine value per transaction
// ----------------------------------------------------------------------------
interface sts_rsp_if import sts_pkg::*; ();

   logic valid;
   logic ready;
   logic signed [SINE_W-1:0] sine_value;

   modport source (output valid, output sine_value, input ready);
   modport sink (input valid, input sine_value, output ready);

endinterface

[src/sts_mul.sv]
// ----------------------------------------------------------------------------
// sts_mul
// shared multiplier, one 36 x 18 partial product per cycle into an accumulator
// ----------------------------------------------------------------------------
module sts_mul import sts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type mul_cmd,
   output mul_rsp_type mul_rsp
);

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [MUL_A_W-1:0]     a_ff, a_in;
   logic [MUL_B_W-1:0]     b_ff, b_in;
   logic [MUL_CNT_W-1:0]   idx_ff, idx_in;
   logic [MUL_P_W-1:0]     acc_ff, acc_in;
   logic [MUL_CHUNK_W-1:0] chunk;
   logic [MUL_A_W+MUL_CHUNK_W-1:0] part;

   assign chunk = b_ff[idx_ff*MUL_CHUNK_W +: MUL_CHUNK_W];
   assign part = a_ff * chunk;

   always_comb begin
      active_in = active_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      if (mul_cmd.start) begin
         active_in = 1'b1;
         a_in = mul_cmd.a;
         b_in = mul_cmd.b;
         idx_in = mul_cmd.chunks - MUL_CNT_W'(1);
         acc_in = '0;
      end else if (active_ff) begin
         acc_in = {acc_ff[MUL_P_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}} + MUL_P_W'(part);
         if (idx_ff == '0) begin
            active_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - MUL_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

[src/sts_reduce.sv]
// ----------------------------------------------------------------------------
// sts_reduce
// folds the angle into [-pi, pi) by compare and subtract of 2*pi multiples
// ----------------------------------------------------------------------------
module sts_reduce import sts_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ANGLE_W-1:0] angle,
   output red_rsp_type               red_rsp
);

   localparam logic [1:0] R_IDLE  = 2'd0;
   localparam logic [1:0] R_WRAP  = 2'd1;
   localparam logic [1:0] R_FOLD  = 2'd2;
   localparam logic [1:0] R_ROUND = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              done_ff, done_in;
   logic [RED_W-1:0]  v_ff, v_in;
   logic [FOLD_W-1:0] j_ff, j_in;
   logic              neg_ff, neg_in;
   logic [XM_W-1:0]   xm_ff, xm_in;

   logic [RED_W-1:0] a48;
   logic [RED_W-1:0] cand;
   logic [RED_W-1:0] r;
   logic [RED_W-1:0] mag;
   logic [RED_W-1:0] mag_rnd;

   assign a48 = {{(RED_W-ANGLE_W-ANGLE_FRAC_SHIFT){angle[ANGLE_W-1]}}, angle,
                 {ANGLE_FRAC_SHIFT{1'b0}}};
   assign cand = v_ff - (TWO_PI_Q48 << j_ff);
   assign r = v_ff - PI_Q48;
   assign mag = r[RED_W-1] ? (~r + RED_W'(1)) : r;
   assign mag_rnd = mag + (RED_W'(1) << (XM_SHIFT-1));

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      v_in = v_ff;
      j_in = j_ff;
      neg_in = neg_ff;
      xm_in = xm_ff;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               v_in = a48 + PI_Q48;
               state_in = R_WRAP;
            end
         end
         R_WRAP: begin
            if (v_ff[RED_W-1]) begin
               v_in = v_ff + (TWO_PI_Q48 << FOLD_TOP);
            end
            j_in = FOLD_TOP;
            state_in = R_FOLD;
         end
         R_FOLD: begin
            if (!cand[RED_W-1]) begin
               v_in = cand;
            end
            j_in = j_ff - FOLD_W'(1);
            if (j_ff == '0) begin
               state_in = R_ROUND;
            end
         end
         R_ROUND: begin
            neg_in = r[RED_W-1];
            xm_in = mag_rnd[XM_SHIFT +: XM_W];
            done_in = 1'b1;
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      j_ff <= j_in;
      neg_ff <= neg_in;
      xm_ff <= xm_in;
   end

   assign red_rsp.done = done_ff;
   assign red_rsp.neg = neg_ff;
   assign red_rsp.xm = xm_ff;

endmodule

[src/sts_series.sv]
// ----------------------------------------------------------------------------
// sts_series
// term sequencer: each term is term * x^2 / ((2k)(2k+1)) on the shared multiplier
// ----------------------------------------------------------------------------
module sts_series import sts_pkg::*; #(
   parameter int MAX_TERMS = DEFAULT_MAX_TERMS
) (
   input  logic             clock,
   input  logic             reset,
   input  red_rsp_type      red_rsp,
   input  logic [THR_W-1:0] stop_threshold,
   output ser_rsp_type      ser_rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_PROD = 3'd3;
   localparam logic [2:0] S_QUOT = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam int RND_W = 70;

   logic [2:0]               state_ff, state_in;
   logic                     done_ff, done_in;
   logic [KCNT_W-1:0]        k_ff, k_in;
   logic [MUL_A_W-1:0]       t_ff, t_in;
   logic [X2_W-1:0]          x2_ff, x2_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     neg_ff, neg_in;
   logic [XM_W-1:0]          xm_ff, xm_in;
   logic [SINE_W-1:0]        sine_ff, sine_in;

   mul_cmd_type              mul_cmd;
   mul_rsp_type              mul_rsp;
   logic [HALF_W-1:0]        half_sel;
   logic [RND_W-1:0]         rnd_sum;
   logic [KCNT_W-1:0]        k_next;
   logic                     stop;
   logic signed [SUM_W-1:0]  t_ext;
   logic signed [SUM_W-1:0]  sat;
   logic signed [SUM_W-1:0]  signed_res;

   sts_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_cmd (mul_cmd),
      .mul_rsp (mul_rsp)
   );

   assign half_sel = (state_ff == S_PROD) ? HALF_TABLE[k_ff[TERM_IDX_W-1:0]] : '0;
   assign rnd_sum = mul_rsp.product[RND_W-1:0] + RND_W'({half_sel, {FRAC_W{1'b0}}})
                    + (RND_W'(1) << (FRAC_W-1));
   assign k_next = k_ff + KCNT_W'(1);
   assign stop = (t_ff <= MUL_A_W'(stop_threshold)) || (k_next >= KCNT_W'(MAX_TERMS));
   assign t_ext = {{(SUM_W-MUL_A_W){1'b0}}, t_ff};
   assign sat = (sum_ff > ONE_Q30) ? ONE_Q30 : ((sum_ff < -ONE_Q30) ? -ONE_Q30 : sum_ff);
   assign signed_res = neg_ff ? -sat : sat;

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      k_in = k_ff;
      t_in = t_ff;
      x2_in = x2_ff;
      sum_in = sum_ff;
      neg_in = neg_ff;
      xm_in = xm_ff;
      sine_in = sine_ff;
      mul_cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (red_rsp.done) begin
               xm_in = red_rsp.xm;
               neg_in = red_rsp.neg;
               mul_cmd.start = 1'b1;
               mul_cmd.a = MUL_A_W'(red_rsp.xm);
               mul_cmd.b = MUL_B_W'(red_rsp.xm);
               mul_cmd.chunks = SQ_CHUNKS;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mul_rsp.done) begin
               x2_in = rnd_sum[FRAC_W +: X2_W];
               t_in = MUL_A_W'(xm_ff);
               sum_in = '0;
               k_in = '0;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            k_in = k_next;
            sum_in = k_ff[0] ? (sum_ff - t_ext) : (sum_ff + t_ext);
            if (stop) begin
               state_in = S_FIN;
            end else begin
               mul_cmd.start = 1'b1;
               mul_cmd.a = t_ff;
               mul_cmd.b = MUL_B_W'(x2_ff);
               mul_cmd.chunks = PROD_CHUNKS;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            if (mul_rsp.done) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a = rnd_sum[FRAC_W +: MUL_A_W];
               mul_cmd.b = MUL_B_W'(RECIP_TABLE[k_ff[TERM_IDX_W-1:0]]);
               mul_cmd.chunks = QUOT_CHUNKS;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            if (mul_rsp.done) begin
               t_in = mul_rsp.product[RECIP_SHIFT +: MUL_A_W];
               state_in = S_ADD;
            end
         end
         S_FIN: begin
            sine_in = signed_res[SINE_W-1:0];
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      t_ff <= t_in;
      x2_ff <= x2_in;
      sum_ff <= sum_in;
      neg_ff <= neg_in;
      xm_ff <= xm_in;
      sine_ff <= sine_in;
   end

   assign ser_rsp.done = done_ff;
   assign ser_rsp.sine_value = sine_ff;

endmodule

[src/sine_taylor_series_unit.sv]
// ----------------------------------------------------------------------------
// sine_taylor_series_unit
// sine of a Q8.24 angle in radians, returned in Q2.30, by Taylor series
//
// req_channel carries one angle per transaction, rsp_channel one sine value.
// csr_write_data is the stop threshold (term magnitude, unsigned Q1.30), written
// on any edge with csr_write_enable high; reset value 10737.
// N terms are summed, N being 1 to MAX_TERMS (twelve by default). the
// range fold runs a wrap step, six compare and subtract steps and a
// rounding step; each term then runs on the shared 36 x 18 multiplier,
// which takes two 18-bit chunks for term * x^2 and three for the
// reciprocal divide.
// one transaction is in flight at a time: req ready is high only while the
// unit is idle, and the next request can be taken while a finished response
// still sits in the output register.
// when the receiver stalls, a new result waits inside the unit until the
// output register frees, and no request is taken meanwhile.
// reset (synchronous) empties the unit and restores the threshold.
// ----------------------------------------------------------------------------
module sine_taylor_series_unit import sts_pkg::*; #(
   parameter int MAX_TERMS = DEFAULT_MAX_TERMS
) (
   input  logic             clock,
   input  logic             reset,
   sts_req_if.sink          req_channel,
   sts_rsp_if.source        rsp_channel,
   input  logic             csr_write_enable,
   input  logic [THR_W-1:0] csr_write_data
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_BUSY = 2'd1;
   localparam logic [1:0] T_HOLD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SINE_W-1:0] rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        slot_free;
   logic        load;
   red_rsp_type red_rsp;
   ser_rsp_type ser_rsp;

   sts_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .angle   (req_channel.angle),
      .red_rsp (red_rsp)
   );

   sts_series #(
      .MAX_TERMS (MAX_TERMS)
   ) u_series (
      .clock          (clock),
      .reset          (reset),
      .red_rsp        (red_rsp),
      .stop_threshold (thr_ff),
      .ser_rsp        (ser_rsp)
   );

   assign req_channel.ready = (state_ff == T_IDLE);
   assign req_accept = req_channel.valid && req_channel.ready;
   assign slot_free = !rsp_valid_ff || rsp_channel.ready;
   assign load = slot_free && (((state_ff == T_BUSY) && ser_rsp.done) || (state_ff == T_HOLD));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (ser_rsp.done) begin
               state_in = slot_free ? T_IDLE : T_HOLD;
            end
         end
         T_HOLD: begin
            if (slot_free) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign thr_in = csr_write_enable ? csr_write_data : thr_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_channel.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in = load ? ser_rsp.sine_value : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         thr_ff <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.sine_value = rsp_data_ff;

endmodule
